### hw/rtl/spmq_pkg.sv
// Package for the stable min-first priority queue.
// Entry type, command and status codes, and the control bundle for the cell row.
// No dependencies.
`default_nettype none

package spmq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_REMOVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t item;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/stable_min_priority_queue_top.sv
// Stable min-first priority queue: a row of CAPACITY cells kept in sorted order.
// Each cell compares and shifts in the same cycle; results go to an output register.
// Throughput: one beat per cycle; stalls while out_valid is high and out_ready low.
// Reset (rst, synchronous): clears the entry count and output valid; slot contents
// are left as they are and are never read before written.
`default_nettype none

module stable_min_priority_queue_top #(
  parameter int CAPACITY = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                cmd,
  input  wire signed [31:0]  value_in,
  input  wire signed [15:0]  priority_in,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] value_out,
  output logic signed [15:0] priority_out,
  output logic [4:0]         occupancy
);
  import spmq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             in_fire;
  logic             full;
  logic             empty;
  cell_ctrl_t       ctrl;
  logic [1:0]       status_next;

  entry_t               cell_entry [CAPACITY];
  logic [CAPACITY-1:0]  cell_keep;
  logic [CAPACITY-1:0]  occupied;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = (count == CAP_CNT);
  assign empty    = (count == '0);

  always_comb begin
    ctrl.ins        = in_fire && (cmd == CMD_INSERT) && !full;
    ctrl.rem        = in_fire && (cmd == CMD_REMOVE) && !empty;
    ctrl.item.value = value_in;
    ctrl.item.prio  = priority_in;
    count_next      = count;
    if (ctrl.ins) begin
      count_next = count + 1'b1;
    end else if (ctrl.rem) begin
      count_next = count - 1'b1;
    end
    if (cmd == CMD_INSERT) begin
      status_next = full ? ST_FULL : ST_INSERTED;
    end else begin
      status_next = empty ? ST_EMPTY : ST_REMOVED;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    assign occupied[i] = IDX < count;

    if (i == 0) begin : g_head
      spmq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (occupied[i]),
        .left_keep   (1'b1),
        .left_entry  (ctrl.item),
        .right_entry (cell_entry[i+1]),
        .keep        (cell_keep[i]),
        .entry       (cell_entry[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      spmq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (occupied[i]),
        .left_keep   (cell_keep[i-1]),
        .left_entry  (cell_entry[i-1]),
        .right_entry ('0),
        .keep        (cell_keep[i]),
        .entry       (cell_entry[i])
      );
    end else begin : g_mid
      spmq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (occupied[i]),
        .left_keep   (cell_keep[i-1]),
        .left_entry  (cell_entry[i-1]),
        .right_entry (cell_entry[i+1]),
        .keep        (cell_keep[i]),
        .entry       (cell_entry[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (in_fire) begin
      status    <= status_next;
      occupancy <= 5'(count_next);
      if (ctrl.rem) begin
        value_out    <= cell_entry[0].value;
        priority_out <= cell_entry[0].prio;
      end else begin
        value_out    <= '0;
        priority_out <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (in_fire && cmd == CMD_INSERT && full) |=> (count == $past(count)) && status == ST_FULL)
    else $error("insert into full queue changed the count");

  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    (in_fire && cmd == CMD_REMOVE && empty) |=> status == ST_EMPTY && count == '0)
    else $error("remove from empty queue not reported");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    occupied[1] |-> cell_entry[0].prio <= cell_entry[1].prio)
    else $error("head entry out of order");

endmodule

`default_nettype wire

### hw/rtl/spmq_cell.sv
// One slot of the sorted queue row.
// Compares its entry against an inserted beat and shifts right on insert, left on remove.
// Depends on spmq_pkg.
`default_nettype none

module spmq_cell (
  input  wire                       clk,
  input  spmq_pkg::cell_ctrl_t      ctrl,
  input  wire                       occupied,
  input  wire                       left_keep,
  input  spmq_pkg::entry_t          left_entry,
  input  spmq_pkg::entry_t          right_entry,
  output logic                      keep,
  output spmq_pkg::entry_t          entry
);
  import spmq_pkg::*;

  // stays put when it is occupied and holds a priority no greater than the new one
  always_comb begin
    keep = occupied && (entry.prio <= ctrl.item.prio);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!keep) begin
        entry <= left_keep ? ctrl.item : left_entry;
      end
    end else if (ctrl.rem) begin
      entry <= right_entry;
    end
  end

endmodule

`default_nettype wire
